@@ rtl/cbm_pkg.sv @@
package cbm_pkg;

  typedef enum logic [2:0] {
    K_CPU_WR = 3'd0, K_CPU_RD = 3'd1, K_VID_RD = 3'd2, K_VID_WR = 3'd3, K_VID_ADDR = 3'd4
  } kind_t;

  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_PROM = 3'd1;
  localparam logic [2:0] TGT_PRAM = 3'd2;
  localparam logic [2:0] TGT_CROM = 3'd3;
  localparam logic [2:0] TGT_CIRAM = 3'd4;
  localparam logic [2:0] TGT_INT = 3'd5;

  localparam logic [15:0] A_PRG_MODE = 16'h5100;
  localparam logic [15:0] A_CHR_MODE = 16'h5101;
  localparam logic [15:0] A_PROT0 = 16'h5102;
  localparam logic [15:0] A_PROT1 = 16'h5103;
  localparam logic [15:0] A_EXT_MODE = 16'h5104;
  localparam logic [15:0] A_NT_SEL = 16'h5105;
  localparam logic [15:0] A_FILL_T = 16'h5106;
  localparam logic [15:0] A_FILL_C = 16'h5107;
  localparam logic [15:0] A_PRG_B0 = 16'h5113;
  localparam logic [15:0] A_PRG_B4 = 16'h5117;
  localparam logic [15:0] A_CHR_B0 = 16'h5120;
  localparam logic [15:0] A_CHR_B11 = 16'h512B;
  localparam logic [15:0] A_CHR_UP = 16'h5130;
  localparam logic [15:0] A_IRQ_LINE = 16'h5203;
  localparam logic [15:0] A_IRQ_STAT = 16'h5204;
  localparam logic [15:0] A_MUL_A = 16'h5205;
  localparam logic [15:0] A_MUL_B = 16'h5206;
  localparam logic [15:0] A_EXT_LO = 16'h5C00;
  localparam logic [15:0] A_PRG_RAM = 16'h6000;
  localparam logic [9:0] ATTR_OFS = 10'h3C0;

  // registered input transaction
  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] address;
    logic [7:0] write_data;
    logic [7:0] prior_data;
    logic sprite_fetch;
    logic in_blanking;
  } req_t;

endpackage

@@ rtl/cbm_chr_map.sv @@
module cbm_chr_map (
  input  logic [1:0]  mode,
  input  logic [12:0] a,
  input  logic        set,
  input  logic [9:0]  banks [12],
  output logic [19:0] ta
);
  logic [1:0] q2;
  logic [2:0] q3;
  logic [9:0] b;
  logic [22:0] r;
  always_comb begin
    q2 = a[12:11];
    q3 = a[12:10];
    b = '0;
    r = '0;
    case (mode)
      2'd0: begin
        b = set ? banks[11] : banks[7];
        r = {b, a};
      end
      2'd1: begin
        b = set ? banks[11] : (a[12] ? banks[7] : banks[3]);
        r = {1'b0, b, a[11:0]};
      end
      2'd2: begin
        b = set ? (q2[0] ? banks[11] : banks[9]) : banks[{1'b0, q2, 1'b1}];
        r = {2'b0, b, a[10:0]};
      end
      default: begin
        b = set ? banks[{2'b10, q3[1:0]}] : banks[{1'b0, q3}];
        r = {3'b0, b, a[9:0]};
      end
    endcase
    ta = r[19:0];
  end
endmodule

@@ rtl/cartridge_bank_mapper_with_irq.sv @@
// Channel  Dir  tdata fields (low bit up)                        tuser
// s_axis   in   address[15:0] write_data[23:16] prior_data[31:24] kind[2:0] sprite_fetch[3]
//               in_blanking[4]
// m_axis   out  read_data[7:0] data_supplied[8] write_absorbed[9]  -
//               target[12:10] target_address[32:13] irq_line[33], pad to 40
// One transaction per cycle unless stalled: input register, then decode and
// state update, then the result register. Ext RAM is read as a request is
// taken, from its incoming address, so data is ready in the input register.
// rst resets all mapper state; extension RAM is swept to zero after reset,
// s_axis_tready low during the sweep.
// Stalls: the output stage is a single register; tready follows m_axis room and the sweep.
module cartridge_bank_mapper_with_irq #(
  parameter int EXT_RAM_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // address, write_data, prior_data
  input  logic [4:0]  s_axis_tuser,  // kind, sprite_fetch, in_blanking
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // read_data, data_supplied, write_absorbed,
                                     // target, target_address, irq_line
);
  import cbm_pkg::*;
  localparam int AW = $clog2(EXT_RAM_DEPTH);

  // pipeline control
  logic   st_v, out_v, clr_busy, adv;
  logic [AW:0] clr_cnt;
  req_t   req;
  logic [7:0] ext_rd;
  logic [7:0] ext_ram [EXT_RAM_DEPTH];

  // mapper state
  logic [1:0] program_mode, pattern_mode, extension_mode;
  logic [1:0] table_select [4];
  logic [7:0] tile_fill_value, color_fill_value;
  logic [1:0] upper_pattern_bits;
  logic [9:0] pattern_banks [12];
  logic [7:0] program_banks [5];
  logic [7:0] factor_a, factor_b, irq_target_line;
  logic       irq_enable, frame_on, irq_pending;
  logic [1:0] match_count;
  logic [13:0] last_video_address;
  logic [7:0] line_count;
  logic [15:0] product;

  // output register is free or draining: stage advances
  assign adv = !out_v || m_axis_tready;
  assign s_axis_tready = adv && !clr_busy;
  assign m_axis_tvalid = out_v;

  // ext RAM address from the incoming or registered request; bypass from the write in flight
  logic [AW-1:0] st_ix, in_ix;
  logic ram_we;
  logic [AW-1:0] ram_wa;
  logic [7:0] ram_wd;
  // CPU window base and name-table offsets both index by the low address bits
  assign in_ix = s_axis_tdata[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= 1'b0;
    end else if (adv) begin
      st_v <= s_axis_tvalid && s_axis_tready;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      req <= '{kind: s_axis_tuser[2:0], address: s_axis_tdata[15:0],
               write_data: s_axis_tdata[23:16], prior_data: s_axis_tdata[31:24],
               sprite_fetch: s_axis_tuser[3], in_blanking: s_axis_tuser[4]};
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) ext_ram[ram_wa] <= ram_wd;
  end

  // read at the request address; held across stalls since req holds
  always_ff @(posedge clk) begin
    if (ram_we && ram_wa == st_ix) ext_rd <= ram_wd;
    else ext_rd <= ext_ram[st_ix];
  end
  // next-cycle index: new request if one is taken, else current one
  assign st_ix = (s_axis_tvalid && s_axis_tready) ? in_ix : req.address[AW-1:0];

  // clearing sweep of extension RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      clr_busy <= 1'b1;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (AW+1)'(EXT_RAM_DEPTH - 1)) clr_busy <= 1'b0;
    end
  end

  // decode of the registered transaction
  logic [7:0]  rd;
  logic        sup, absorbed;
  logic [2:0]  tgt;
  logic [19:0] ta;
  logic [15:0] a;
  logic [13:0] va;
  logic [1:0]  w;
  logic [7:0]  pb;
  logic [1:0]  sel;
  logic [19:0] chr_ta;
  logic        do_st, ext_we, clr_irq, cfg_we, scan;
  logic [1:0]  mc_next;

  cbm_chr_map u_chr (
    .mode(pattern_mode), .a(va[12:0]), .set(req.sprite_fetch),
    .banks(pattern_banks), .ta(chr_ta)
  );

  always_comb begin
    a = req.address;
    va = a[13:0];
    w = a[14:13];
    do_st = st_v && adv;
    rd = req.prior_data;
    sup = 1'b0; absorbed = 1'b0; tgt = TGT_NONE; ta = '0;
    ext_we = 1'b0; clr_irq = 1'b0; cfg_we = 1'b0; scan = 1'b0;
    pb = '0;
    sel = table_select[va[11:10]];
    case (req.kind)
      K_CPU_WR, K_CPU_RD: begin
        if (a >= A_EXT_LO && a < A_PRG_RAM) begin
          tgt = TGT_INT; ta = 20'(a[AW-1:0]);
          if (req.kind == K_CPU_WR) begin
            if ((extension_mode < 2'd2 && req.in_blanking) || extension_mode == 2'd2) begin
              ext_we = 1'b1; absorbed = 1'b1;
            end
          end else if (extension_mode >= 2'd2) begin
            rd = ext_rd; sup = 1'b1;
          end
        end else if (a >= A_PRG_RAM) begin
          if (!a[15]) pb = {1'b0, program_banks[0][6:0]};
          else begin
            case (program_mode)
              2'd0: pb = (program_banks[4] & 8'h7C) | {6'd0, w} | 8'h80;
              2'd1: pb = !w[1] ? ((program_banks[2] & 8'hFE) | {7'd0, w[0]}) :
                         ((program_banks[4] & 8'hFE) | {7'd0, w[0]} | 8'h80);
              2'd2: pb = !w[1] ? ((program_banks[2] & 8'hFE) | {7'd0, w[0]}) :
                         (w == 2'd2) ? program_banks[3] : (program_banks[4] | 8'h80);
              default: pb = (w == 2'd3) ? (program_banks[4] | 8'h80) :
                            program_banks[3'd1 + {1'b0, w}];
            endcase
          end
          tgt = pb[7] ? TGT_PROM : TGT_PRAM;
          ta = {pb[6:0], a[12:0]};
        end else if (req.kind == K_CPU_WR) begin
          tgt = TGT_INT; ta = 20'(a);
          if (a == A_PRG_MODE || a == A_CHR_MODE || a == A_PROT0 || a == A_PROT1 ||
              a == A_EXT_MODE || a == A_NT_SEL || a == A_FILL_T || a == A_FILL_C ||
              (a >= A_PRG_B0 && a <= A_PRG_B4) || (a >= A_CHR_B0 && a <= A_CHR_B11) ||
              a == A_CHR_UP || a == A_IRQ_LINE || a == A_IRQ_STAT || a == A_MUL_A ||
              a == A_MUL_B) begin
            cfg_we = 1'b1;
          end else begin
            tgt = TGT_NONE; ta = '0;
          end
        end else begin
          tgt = TGT_INT; ta = 20'(a); sup = 1'b1;
          if (a == A_IRQ_STAT) begin
            rd = {frame_on, irq_pending, 6'd0}; clr_irq = 1'b1;
          end else if (a == A_MUL_A) rd = product[7:0];
          else if (a == A_MUL_B) rd = product[15:8];
          else begin
            tgt = TGT_NONE; ta = '0; sup = 1'b0;
          end
        end
      end
      K_VID_RD, K_VID_WR: begin
        if (!va[13]) begin
          tgt = TGT_CROM; ta = chr_ta;
        end else begin
          case (sel)
            2'd0: begin tgt = TGT_CIRAM; ta = {10'd0, va[9:0]}; end
            2'd1: begin tgt = TGT_CIRAM; ta = {9'd0, 1'b1, va[9:0]}; end
            2'd2: begin
              tgt = TGT_INT; ta = 20'(va[AW-1:0]);
              if (req.kind == K_VID_RD) begin rd = ext_rd; sup = 1'b1; end
              else begin ext_we = 1'b1; absorbed = 1'b1; end
            end
            default: begin
              if (req.kind == K_VID_RD) begin
                tgt = TGT_INT; sup = 1'b1;
                rd = (va[9:0] < ATTR_OFS) ? tile_fill_value : color_fill_value;
              end
            end
          endcase
        end
      end
      K_VID_ADDR: scan = 1'b1;
      default: ;
    endcase
    mc_next = (va >= 14'h2000 && va <= 14'h2FFF && va == last_video_address) ?
              match_count + 2'd1 : 2'd0;
  end

  assign ram_we = clr_busy || (do_st && ext_we);
  assign ram_wa = clr_busy ? clr_cnt[AW-1:0] : req.address[AW-1:0];
  assign ram_wd = clr_busy ? 8'd0 : req.write_data;

  // current factors, so a read right after a factor write sees the new product
  assign product = factor_a * factor_b;

  logic irq_p_next;
  always_ff @(posedge clk) begin
    if (rst) begin
      program_mode <= 2'd3; pattern_mode <= '0; extension_mode <= '0;
      for (int i = 0; i < 4; i++) table_select[i] <= '0;
      tile_fill_value <= '0; color_fill_value <= '0; upper_pattern_bits <= '0;
      for (int i = 0; i < 12; i++) pattern_banks[i] <= '0;
      for (int i = 0; i < 4; i++) program_banks[i] <= '0;
      program_banks[4] <= 8'hFF;
      factor_a <= 8'hFF; factor_b <= 8'hFF; irq_target_line <= '0; irq_enable <= 1'b0;
      match_count <= '0; last_video_address <= '0; frame_on <= 1'b0;
      line_count <= '0; irq_pending <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (adv) out_v <= st_v;
      if (do_st && cfg_we) begin
        case (a)
          A_PRG_MODE: program_mode <= req.write_data[1:0];
          A_CHR_MODE: pattern_mode <= req.write_data[1:0];
          A_EXT_MODE: extension_mode <= req.write_data[1:0];
          A_NT_SEL: for (int i = 0; i < 4; i++)
                      table_select[i] <= req.write_data[2*i +: 2];
          A_FILL_T: tile_fill_value <= req.write_data;
          A_FILL_C: color_fill_value <= {4{req.write_data[1:0]}};
          A_CHR_UP: upper_pattern_bits <= req.write_data[1:0];
          A_IRQ_LINE: irq_target_line <= req.write_data;
          A_IRQ_STAT: irq_enable <= req.write_data[7];
          A_MUL_A: factor_a <= req.write_data;
          A_MUL_B: factor_b <= req.write_data;
          default: begin
            if (a >= A_PRG_B0 && a <= A_PRG_B4)
              program_banks[3'(a - A_PRG_B0)] <= req.write_data;
            else if (a >= A_CHR_B0 && a <= A_CHR_B11)
              pattern_banks[4'(a - A_CHR_B0)] <= {upper_pattern_bits, req.write_data};
          end
        endcase
      end
      if (do_st && clr_irq) irq_pending <= 1'b0;
      if (do_st && scan) begin
        last_video_address <= va;
        if (mc_next == 2'd2) begin
          match_count <= '0;
          if (!frame_on) begin
            frame_on <= 1'b1; line_count <= '0;
          end else begin
            line_count <= line_count + 8'd1;
            if (line_count + 8'd1 == irq_target_line) irq_pending <= 1'b1;
          end
        end else match_count <= mc_next;
      end
    end
  end

  // irq after this transaction's update
  always_comb begin
    irq_p_next = irq_pending;
    if (clr_irq) irq_p_next = 1'b0;
    if (scan && mc_next == 2'd2 && frame_on && line_count + 8'd1 == irq_target_line)
      irq_p_next = 1'b1;
  end

  logic irq_en_next;
  assign irq_en_next = (cfg_we && a == A_IRQ_STAT) ? req.write_data[7] : irq_enable;

  always_ff @(posedge clk) begin
    if (do_st) begin
      m_axis_tdata <= {6'd0, irq_p_next & irq_en_next, ta, tgt, absorbed, sup, rd};
    end
  end
endmodule

@@ tb/sv/cbm_access_checker.sv @@
module cbm_access_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [4:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count,
  output int          pending,
  output int          accesses_seen,
  output int          results_seen,
  output int          irq_results
);
  import cbm_pkg::*;

  // packed from the top bit down, so the layout matches m_axis_tdata[33:0]
  typedef struct packed {
    logic        irq_line;
    logic [19:0] target_address;
    logic [2:0]  target;
    logic        write_absorbed;
    logic        data_supplied;
    logic [7:0]  read_data;
  } bus_result_t;

  bus_result_t expected_results[$];

  // mapper state mirror
  logic [1:0] prg_mode, chr_mode, ext_mode;
  logic [1:0] nt_sel[4];
  logic [7:0] tile_fill, color_fill;
  logic [1:0] chr_upper;
  logic [9:0] pat_bank[12];
  logic [7:0] prog_bank[5];
  logic [7:0] mul_a, mul_b, irq_line_target;
  logic       irq_en;
  logic [7:0] ext_ram[1024];
  logic [1:0] match_cnt;
  logic [13:0] last_vaddr;
  logic       frame_active, irq_flag;
  logic [7:0] line_cnt;

  task automatic clear_state();
    prg_mode = 2'd3; chr_mode = '0; ext_mode = '0;
    for (int i = 0; i < 4; i++) nt_sel[i] = '0;
    tile_fill = '0; color_fill = '0; chr_upper = '0;
    for (int i = 0; i < 12; i++) pat_bank[i] = '0;
    for (int i = 0; i < 5; i++) prog_bank[i] = '0;
    prog_bank[4] = 8'hFF;
    mul_a = 8'hFF; mul_b = 8'hFF; irq_line_target = '0; irq_en = 1'b0;
    for (int i = 0; i < 1024; i++) ext_ram[i] = '0;
    match_cnt = '0; last_vaddr = '0; frame_active = 1'b0; line_cnt = '0; irq_flag = 1'b0;
  endtask

  function automatic void map_program(input logic [15:0] a, output logic [2:0] tgt,
                                      output logic [19:0] ta);
    logic [7:0] b;
    logic [1:0] w;
    w = a[14:13];
    if (a < 16'h8000) b = {1'b0, prog_bank[0][6:0]};
    else begin
      case (prg_mode)
        2'd0: b = (prog_bank[4] & 8'h7C) | {6'd0, w} | 8'h80;
        2'd1: b = (w < 2) ? ((prog_bank[2] & 8'hFE) | {7'd0, w[0]})
                          : ((prog_bank[4] & 8'hFE) | {7'd0, w[0]} | 8'h80);
        2'd2: begin
          if (w < 2) b = (prog_bank[2] & 8'hFE) | {7'd0, w[0]};
          else if (w == 2) b = prog_bank[3];
          else b = prog_bank[4] | 8'h80;
        end
        default: b = (w < 3) ? prog_bank[1 + w] : (prog_bank[4] | 8'h80);
      endcase
    end
    tgt = b[7] ? TGT_PROM : TGT_PRAM;
    ta = {b[6:0], a[12:0]};
  endfunction

  function automatic logic [19:0] map_pattern(input logic [13:0] a, input logic fg);
    logic [31:0] r;
    int q;
    case (chr_mode)
      2'd0: r = ({22'd0, fg ? pat_bank[11] : pat_bank[7]} << 13) | 32'(a & 14'h1FFF);
      2'd1: r = ({22'd0, fg ? pat_bank[11] : (a[12] ? pat_bank[7] : pat_bank[3])} << 12)
                | 32'(a & 14'h0FFF);
      2'd2: begin
        q = int'(a[12:11]);
        r = ({22'd0, fg ? (q[0] ? pat_bank[11] : pat_bank[9]) : pat_bank[1 + 2 * q]} << 11)
            | 32'(a & 14'h07FF);
      end
      default: begin
        q = int'(a[12:10]);
        r = ({22'd0, fg ? pat_bank[8 + (q & 3)] : pat_bank[q]} << 10) | 32'(a & 14'h03FF);
      end
    endcase
    return r[19:0];
  endfunction

  task automatic watch_scanline(input logic [13:0] a);
    if (a >= 14'h2000 && a <= 14'h2FFF && a == last_vaddr) match_cnt = match_cnt + 2'd1;
    else match_cnt = '0;
    if (match_cnt == 2'd2) begin
      match_cnt = '0;
      if (!frame_active) begin
        frame_active = 1'b1;
        line_cnt = '0;
      end else begin
        line_cnt = line_cnt + 8'd1;
        if (line_cnt == irq_line_target) irq_flag = 1'b1;
      end
    end
    last_vaddr = a;
  endtask

  // Apply one bus access to the mirror and return what the mapper should report.
  task automatic predict_access(input logic [31:0] d, input logic [4:0] u,
                                output bus_result_t r);
    logic [15:0] addr;
    logic [7:0]  wd;
    logic [13:0] va;
    logic [9:0]  off;
    logic [9:0]  ix;
    logic [1:0]  sel;
    logic [15:0] prod;
    logic [2:0]  kd;
    addr = d[15:0]; wd = d[23:16]; kd = u[2:0];
    ix = addr[9:0];
    r = '0;
    r.read_data = d[31:24];
    prod = mul_a * mul_b;
    if (kd == K_CPU_WR || kd == K_CPU_RD) begin
      if (addr >= A_EXT_LO && addr < A_PRG_RAM) begin
        r.target = TGT_INT; r.target_address = 20'(ix);
        if (kd == K_CPU_WR) begin
          if ((ext_mode < 2 && u[4]) || ext_mode == 2) begin
            ext_ram[ix] = wd;
            r.write_absorbed = 1'b1;
          end
        end else if (ext_mode >= 2) begin
          r.read_data = ext_ram[ix]; r.data_supplied = 1'b1;
        end
      end else if (addr >= A_PRG_RAM) begin
        map_program(addr, r.target, r.target_address);
      end else if (kd == K_CPU_WR) begin
        r.target = TGT_INT; r.target_address = 20'(addr);
        if (addr == A_PRG_MODE) prg_mode = wd[1:0];
        else if (addr == A_CHR_MODE) chr_mode = wd[1:0];
        else if (addr == A_PROT0 || addr == A_PROT1) ;
        else if (addr == A_EXT_MODE) ext_mode = wd[1:0];
        else if (addr == A_NT_SEL) begin
          nt_sel[0] = wd[1:0]; nt_sel[1] = wd[3:2]; nt_sel[2] = wd[5:4]; nt_sel[3] = wd[7:6];
        end
        else if (addr == A_FILL_T) tile_fill = wd;
        else if (addr == A_FILL_C) color_fill = {4{wd[1:0]}};
        else if (addr >= A_PRG_B0 && addr <= A_PRG_B4) prog_bank[addr - A_PRG_B0] = wd;
        else if (addr >= A_CHR_B0 && addr <= A_CHR_B11) pat_bank[addr - A_CHR_B0] = {chr_upper, wd};
        else if (addr == A_CHR_UP) chr_upper = wd[1:0];
        else if (addr == A_IRQ_LINE) irq_line_target = wd;
        else if (addr == A_IRQ_STAT) irq_en = wd[7];
        else if (addr == A_MUL_A) mul_a = wd;
        else if (addr == A_MUL_B) mul_b = wd;
        else begin
          r.target = TGT_NONE; r.target_address = '0;
        end
      end else begin
        r.target = TGT_INT; r.target_address = 20'(addr); r.data_supplied = 1'b1;
        if (addr == A_IRQ_STAT) begin
          r.read_data = {frame_active, irq_flag, 6'd0};
          irq_flag = 1'b0;
        end
        else if (addr == A_MUL_A) r.read_data = prod[7:0];
        else if (addr == A_MUL_B) r.read_data = prod[15:8];
        else begin
          r.target = TGT_NONE; r.target_address = '0; r.data_supplied = 1'b0;
        end
      end
    end else if (kd == K_VID_RD || kd == K_VID_WR) begin
      va = addr[13:0];
      if (va < 14'h2000) begin
        r.target = TGT_CROM; r.target_address = map_pattern(va, u[3]);
      end else begin
        off = va[9:0];
        sel = nt_sel[va[11:10]];
        if (sel == 0) begin
          r.target = TGT_CIRAM; r.target_address = 20'(off);
        end else if (sel == 1) begin
          r.target = TGT_CIRAM; r.target_address = 20'(off) + 20'h400;
        end else if (sel == 2) begin
          r.target = TGT_INT; r.target_address = 20'(off);
          if (kd == K_VID_RD) begin
            r.read_data = ext_ram[off]; r.data_supplied = 1'b1;
          end else begin
            ext_ram[off] = wd; r.write_absorbed = 1'b1;
          end
        end else if (kd == K_VID_RD) begin
          r.target = TGT_INT; r.data_supplied = 1'b1;
          r.read_data = (off < ATTR_OFS) ? tile_fill : color_fill;
        end
      end
    end else if (kd == K_VID_ADDR) begin
      watch_scanline(addr[13:0]);
    end
    r.irq_line = irq_flag & irq_en;
  endtask

  bus_result_t exp_r, got_r;

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_results.delete();
      fail_count <= 0; accesses_seen <= 0; results_seen <= 0; irq_results <= 0;
      pending = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_access(s_axis_tdata, s_axis_tuser, exp_r);
        expected_results.push_back(exp_r);
        accesses_seen <= accesses_seen + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = m_axis_tdata[33:0];
        results_seen <= results_seen + 1;
        if (got_r.irq_line) irq_results <= irq_results + 1;
        if (expected_results.size() == 0) begin
          $error("result with no access outstanding: %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            fail_count <= fail_count + 1;
            if (got_r.read_data !== exp_r.read_data)
              $error("read_data exp %h got %h", exp_r.read_data, got_r.read_data);
            if (got_r.data_supplied !== exp_r.data_supplied)
              $error("data_supplied exp %b got %b", exp_r.data_supplied, got_r.data_supplied);
            if (got_r.write_absorbed !== exp_r.write_absorbed)
              $error("write_absorbed exp %b got %b", exp_r.write_absorbed, got_r.write_absorbed);
            if (got_r.target !== exp_r.target)
              $error("target exp %0d got %0d", exp_r.target, got_r.target);
            if (got_r.target_address !== exp_r.target_address)
              $error("target_address exp %h got %h", exp_r.target_address,
                     got_r.target_address);
            if (got_r.irq_line !== exp_r.irq_line)
              $error("irq_line exp %b got %b", exp_r.irq_line, got_r.irq_line);
          end
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

@@ tb/sv/tb_cartridge_bank_mapper_with_irq.sv @@
module tb_cartridge_bank_mapper_with_irq;
  import cbm_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [4:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  int fail_count, pending, accesses_seen, results_seen, irq_results;

  // 0: sender idles 37%, receiver 48%; 1: swapped; 2: no idling
  int idle_phase;
  int send_idle_pct, recv_idle_pct;
  int sent;
  int quiet_cycles;
  int hold_left;
  bit hold_done;

  localparam int RANDOM_ITEMS = 1850;
  // covers the extension RAM sweep after reset plus the long receiver hold
  localparam int QUIET_LIMIT = 6000;

  cartridge_bank_mapper_with_irq uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  cbm_access_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending),
    .accesses_seen(accesses_seen), .results_seen(results_seen), .irq_results(irq_results)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always_comb begin
    send_idle_pct = (idle_phase == 0) ? 37 : (idle_phase == 1) ? 48 : 0;
    recv_idle_pct = (idle_phase == 0) ? 48 : (idle_phase == 1) ? 37 : 0;
  end

  // Receiver: random stalls, plus one long hold at the start of the no-idle phase
  // so the pipeline backs up and s_axis_tready drops while the sender keeps offering.
  initial begin
    m_axis_tready = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && idle_phase == 2) begin
        hold_done = 1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // One input transaction; returns after the edge that accepted it.
  task automatic send_access(input kind_t kd, input logic [15:0] addr,
                             input logic [7:0] wd, input logic [7:0] pd,
                             input logic fg, input logic blank);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = {pd, wd, addr};
    s_axis_tuser = {blank, fg, kd};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic cpu_write(input logic [15:0] addr, input logic [7:0] wd);
    send_access(K_CPU_WR, addr, wd, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic cpu_read(input logic [15:0] addr);
    send_access(K_CPU_RD, addr, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Register address drawn from the decoded set.
  function automatic logic [15:0] pick_register();
    case ($urandom_range(7))
      0: return A_PRG_MODE + 16'($urandom_range(7));
      1: return A_PRG_B0 + 16'($urandom_range(4));
      2, 3: return A_CHR_B0 + 16'($urandom_range(11));
      4: return A_CHR_UP;
      5: return A_IRQ_LINE + 16'($urandom_range(3));
      6: return A_NT_SEL;
      default: return A_EXT_MODE;
    endcase
  endfunction

  task automatic random_access();
    logic [15:0] a;
    logic [7:0]  wd;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      a = pick_register();
      // keep the interrupt line low so that scanline matches actually reach it
      wd = (a == A_IRQ_LINE && $urandom_range(3) != 0) ? 8'($urandom_range(6)) : 8'($urandom);
      cpu_write(a, wd);
    end else if (pick < 28) begin
      cpu_read(A_IRQ_STAT + 16'($urandom_range(2)));
    end else if (pick < 38) begin
      a = A_EXT_LO + 16'($urandom_range(1023));
      if ($urandom_range(1)) cpu_write(a, 8'($urandom));
      else cpu_read(a);
    end else if (pick < 50) begin
      a = A_PRG_RAM + 16'($urandom_range(16'h9FFF));
      if ($urandom_range(1)) cpu_write(a, 8'($urandom));
      else cpu_read(a);
    end else if (pick < 70) begin
      send_access($urandom_range(1) ? K_VID_RD : K_VID_WR, 16'($urandom), 8'($urandom),
                  8'($urandom), 1'($urandom), 1'($urandom));
    end else if (pick < 88) begin
      // a scanline: the same name-table address fetched three times in a row
      a = {2'($urandom), 14'h2000 + 14'($urandom_range(14'h0FFF))};
      for (int i = 0; i < 3; i++)
        send_access(K_VID_ADDR, a, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      send_access(kind_t'($urandom_range(4)), 16'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst = 1;
    idle_phase = 0;
    sent = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset product, status, protect and unused registers, ext RAM modes,
    // program window extremes, pattern page sizes, fill, folding, scanline detect.
    cpu_read(A_MUL_A);
    cpu_read(A_MUL_B);
    cpu_write(A_PROT0, 8'hFF);
    cpu_write(16'h0000, 8'hFF);
    cpu_read(16'h5000);
    send_access(K_CPU_WR, 16'h5FFF, 8'hA5, 8'h00, 0, 1);  // ext RAM, blanked, mode 0
    cpu_read(16'h5FFF);                                     // mode 0: open bus
    cpu_write(A_EXT_MODE, 8'h02);
    cpu_write(A_NT_SEL, 8'hE4);                             // tables 0,1,2,3 -> modes 0..3
    cpu_write(A_FILL_T, 8'hFF);
    cpu_write(A_FILL_C, 8'h03);
    send_access(K_VID_RD, 16'hFBFF, 8'h00, 8'h11, 0, 0);   // ext RAM name table via 0x3xxx fold
    send_access(K_VID_WR, 16'h2C00, 8'h5A, 8'h00, 0, 0);   // fill write ignored
    send_access(K_VID_WR, 16'h2BFF, 8'h3C, 8'h00, 0, 0);   // ext RAM as name table
    cpu_write(A_CHR_UP, 8'h03);
    cpu_write(A_CHR_B11, 8'hFF);                            // wide bank, truncated
    send_access(K_VID_RD, 16'h1FFF, 8'h00, 8'hFF, 1, 1);
    cpu_write(A_PRG_MODE, 8'h00);
    cpu_read(16'hFFFF);
    cpu_read(16'h6000);
    cpu_write(A_IRQ_STAT, 8'h80);
    for (int i = 0; i < 6; i++)                             // two detections: frame, line 1
      send_access(K_VID_ADDR, 16'h2000, 8'h00, 8'h00, 0, 0);
    cpu_read(A_IRQ_STAT);

    for (int i = 0; sent < RANDOM_ITEMS + 25; i++) begin
      idle_phase = (sent * 3) / (RANDOM_ITEMS + 25);
      random_access();
    end

    @(negedge clk);
    s_axis_tvalid = 0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    $display("%0d accesses checked against %0d results, %0d with the interrupt line up",
             accesses_seen, results_seen, irq_results);
    $display("covered registers, ext RAM modes, program and pattern mapping, scanline irq");
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
